// ----- hw/rtl/motor_motion_mode_fsm_top_macros.svh -----
// -----------------------------------------------------------------------------
// Motor motion-mode supervisor assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef MOTOR_MOTION_MODE_FSM_TOP_MACROS_SVH
`define MOTOR_MOTION_MODE_FSM_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: whenever ante holds, cons holds too.
`define MMFSM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define MMFSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define MMFSM_ASSERT_IMPL(lbl, ante, cons)
`define MMFSM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/mmfsm_pkg.sv -----
// -----------------------------------------------------------------------------
// Motor motion-mode supervisor package
// Mode and event codes, command codes and the update bundle shared by the
// transition logic and the top level.
// -----------------------------------------------------------------------------
package mmfsm_pkg;

	localparam int MODE_W  = 4;
	localparam int EVENT_W = 4;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_UNINIT   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_IDLE     = 4'd1;
	localparam logic [MODE_W-1:0] MODE_READY    = 4'd2;
	localparam logic [MODE_W-1:0] MODE_ACCEL    = 4'd3;
	localparam logic [MODE_W-1:0] MODE_RUNNING  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_DECEL    = 4'd5;
	localparam logic [MODE_W-1:0] MODE_STOPPING = 4'd6;
	localparam logic [MODE_W-1:0] MODE_ERROR    = 4'd7;
	localparam logic [MODE_W-1:0] MODE_HOMING   = 4'd8;

	// Event codes
	localparam logic [EVENT_W-1:0] EV_INIT      = 4'd0;
	localparam logic [EVENT_W-1:0] EV_ENABLE    = 4'd1;
	localparam logic [EVENT_W-1:0] EV_DISABLE   = 4'd2;
	localparam logic [EVENT_W-1:0] EV_START     = 4'd3;
	localparam logic [EVENT_W-1:0] EV_DONE      = 4'd4;
	localparam logic [EVENT_W-1:0] EV_STOP      = 4'd5;
	localparam logic [EVENT_W-1:0] EV_ESTOP     = 4'd6;
	localparam logic [EVENT_W-1:0] EV_FAULT     = 4'd7;
	localparam logic [EVENT_W-1:0] EV_CLEARED   = 4'd8;
	localparam logic [EVENT_W-1:0] EV_HOME      = 4'd9;
	localparam logic [EVENT_W-1:0] EV_HOME_DONE = 4'd10;

	// Command codes
	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_RESET = 1'b1;

	// Outcome of one transaction on the mode registers
	typedef struct packed {
		logic              changed;
		logic [MODE_W-1:0] mode;
		logic [MODE_W-1:0] prior;
		logic              may_move;
		logic              in_motion;
	} mmfsm_upd_t;

endpackage

// ----- hw/rtl/mmfsm_next.sv -----
// -----------------------------------------------------------------------------
// Motor motion-mode transition logic
// Looks up the next mode from the current mode and one command, and derives
// the change flag, the prior mode and the motion flags.
// -----------------------------------------------------------------------------
module mmfsm_next (
	input  logic [mmfsm_pkg::MODE_W-1:0]  mode,
	input  logic [mmfsm_pkg::MODE_W-1:0]  prior,
	input  logic                          command,
	input  logic [mmfsm_pkg::EVENT_W-1:0] event_code,
	output mmfsm_pkg::mmfsm_upd_t         upd
);

	logic [mmfsm_pkg::MODE_W-1:0] table_mode;
	logic [mmfsm_pkg::MODE_W-1:0] next_mode;
	logic                         moved;

	// Look up the transition table; undefined pairs keep the mode
	always_comb begin
		table_mode = mode;
		case (mode)
			mmfsm_pkg::MODE_UNINIT: begin
				if (event_code == mmfsm_pkg::EV_INIT) table_mode = mmfsm_pkg::MODE_IDLE;
			end
			mmfsm_pkg::MODE_IDLE: begin
				if (event_code == mmfsm_pkg::EV_ENABLE) table_mode = mmfsm_pkg::MODE_READY;
			end
			mmfsm_pkg::MODE_READY: begin
				case (event_code)
					mmfsm_pkg::EV_DISABLE: table_mode = mmfsm_pkg::MODE_IDLE;
					mmfsm_pkg::EV_START:   table_mode = mmfsm_pkg::MODE_ACCEL;
					mmfsm_pkg::EV_HOME:    table_mode = mmfsm_pkg::MODE_HOMING;
					mmfsm_pkg::EV_FAULT:   table_mode = mmfsm_pkg::MODE_ERROR;
					default:               table_mode = mode;
				endcase
			end
			mmfsm_pkg::MODE_ACCEL: begin
				case (event_code)
					mmfsm_pkg::EV_DONE:  table_mode = mmfsm_pkg::MODE_RUNNING;
					mmfsm_pkg::EV_STOP:  table_mode = mmfsm_pkg::MODE_DECEL;
					mmfsm_pkg::EV_ESTOP: table_mode = mmfsm_pkg::MODE_STOPPING;
					mmfsm_pkg::EV_FAULT: table_mode = mmfsm_pkg::MODE_ERROR;
					default:             table_mode = mode;
				endcase
			end
			mmfsm_pkg::MODE_RUNNING: begin
				case (event_code)
					mmfsm_pkg::EV_DONE:  table_mode = mmfsm_pkg::MODE_DECEL;
					mmfsm_pkg::EV_STOP:  table_mode = mmfsm_pkg::MODE_DECEL;
					mmfsm_pkg::EV_ESTOP: table_mode = mmfsm_pkg::MODE_STOPPING;
					mmfsm_pkg::EV_FAULT: table_mode = mmfsm_pkg::MODE_ERROR;
					default:             table_mode = mode;
				endcase
			end
			mmfsm_pkg::MODE_DECEL: begin
				case (event_code)
					mmfsm_pkg::EV_DONE:  table_mode = mmfsm_pkg::MODE_READY;
					mmfsm_pkg::EV_ESTOP: table_mode = mmfsm_pkg::MODE_STOPPING;
					mmfsm_pkg::EV_FAULT: table_mode = mmfsm_pkg::MODE_ERROR;
					default:             table_mode = mode;
				endcase
			end
			mmfsm_pkg::MODE_STOPPING: begin
				case (event_code)
					mmfsm_pkg::EV_DONE:  table_mode = mmfsm_pkg::MODE_READY;
					mmfsm_pkg::EV_FAULT: table_mode = mmfsm_pkg::MODE_ERROR;
					default:             table_mode = mode;
				endcase
			end
			mmfsm_pkg::MODE_HOMING: begin
				case (event_code)
					mmfsm_pkg::EV_HOME_DONE: table_mode = mmfsm_pkg::MODE_READY;
					mmfsm_pkg::EV_ESTOP:     table_mode = mmfsm_pkg::MODE_STOPPING;
					mmfsm_pkg::EV_FAULT:     table_mode = mmfsm_pkg::MODE_ERROR;
					default:                 table_mode = mode;
				endcase
			end
			mmfsm_pkg::MODE_ERROR: begin
				if (event_code == mmfsm_pkg::EV_CLEARED) table_mode = mmfsm_pkg::MODE_IDLE;
			end
			default: begin
				table_mode = mode;
			end
		endcase
	end

	// Force idle on a reset command, which always counts as a transition
	assign next_mode = (command == mmfsm_pkg::CMD_RESET) ? mmfsm_pkg::MODE_IDLE : table_mode;
	assign moved     = (command == mmfsm_pkg::CMD_RESET) || (table_mode != mode);

	// Build the update bundle
	always_comb begin
		upd.changed   = moved;
		upd.mode      = next_mode;
		upd.prior     = moved ? mode : prior;
		upd.may_move  = (next_mode == mmfsm_pkg::MODE_READY);
		upd.in_motion = (next_mode == mmfsm_pkg::MODE_ACCEL) ||
		                (next_mode == mmfsm_pkg::MODE_RUNNING) ||
		                (next_mode == mmfsm_pkg::MODE_DECEL);
	end

endmodule

// ----- hw/rtl/motor_motion_mode_fsm_top.sv -----
// Each accepted transaction's result is loaded into the output register and shows in the cycle after acceptance.
// Throughput: one transaction per cycle; the input stalls only while a result waits stalled.
// The mode register update and the result load happen at the same edge, so the next
// transaction sees the new mode at once.
// Reset: arst_n low clears the mode and prior mode to uninitialized and drops out_valid.
// -----------------------------------------------------------------------------
// Motor motion-mode supervisor top level
// Nine-mode motor supervisor: one event or forced reset in, one mode report out.
// -----------------------------------------------------------------------------
`include "motor_motion_mode_fsm_top_macros.svh"

module motor_motion_mode_fsm_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [mmfsm_pkg::EVENT_W-1:0] event_code,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          changed,
	output logic [mmfsm_pkg::MODE_W-1:0]  mode_now,
	output logic [mmfsm_pkg::MODE_W-1:0]  mode_before,
	output logic                          may_move,
	output logic                          in_motion
);

	logic                         in_accept;
	logic [mmfsm_pkg::MODE_W-1:0] mode_q;
	logic [mmfsm_pkg::MODE_W-1:0] prior_q;
	logic                         out_valid_q;
	mmfsm_pkg::mmfsm_upd_t        upd;
	mmfsm_pkg::mmfsm_upd_t        res_q;

	// Stall input only when a result is held and the sink stalls
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	mmfsm_next u_next (
		.mode       (mode_q),
		.prior      (prior_q),
		.command    (command),
		.event_code (event_code),
		.upd        (upd)
	);

	// Advance the mode registers on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= mmfsm_pkg::MODE_UNINIT;
			prior_q <= mmfsm_pkg::MODE_UNINIT;
		end else if (in_accept) begin
			mode_q  <= upd.mode;
			prior_q <= upd.prior;
		end
	end

	// Track result occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= upd;
		end
	end

	assign out_valid   = out_valid_q;
	assign changed     = res_q.changed;
	assign mode_now    = res_q.mode;
	assign mode_before = res_q.prior;
	assign may_move    = res_q.may_move;
	assign in_motion   = res_q.in_motion;

	// Forced reset lands in idle and reports a change
	`MMFSM_ASSERT_NEXT(a_force_idle, in_accept && (command == mmfsm_pkg::CMD_RESET), out_valid && changed && (mode_now == mmfsm_pkg::MODE_IDLE) && (mode_q == mmfsm_pkg::MODE_IDLE))
	// Shown result always tracks the live mode registers
	`MMFSM_ASSERT_IMPL(a_res_tracks, out_valid, (mode_now == mode_q) && (mode_before == prior_q))
	// Mode holds without an accepted transaction
	`MMFSM_ASSERT_NEXT(a_mode_hold, !in_accept, $stable(mode_q) && $stable(prior_q))
	// Ready and motion flags are exclusive
	`MMFSM_ASSERT_IMPL(a_flags_excl, out_valid, !(may_move && in_motion))
	// An unchanged result leaves the mode where it was
	`MMFSM_ASSERT_NEXT(a_no_change, in_accept && !upd.changed, mode_q == $past(mode_q))

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Motor motion-mode supervisor testbench
// Drives events and forced resets into the supervisor with random idle bursts
// on both channels and checks each mode report against a local prediction of
// the transition table, current mode and prior mode.
// -----------------------------------------------------------------------------
module testbench;
	import mmfsm_pkg::*;

	localparam int unsigned RAND_ITEMS   = 1130;
	localparam int unsigned TAIL_ITEMS   = 100;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned SQUEEZE_LEN  = 60;

	// Codes outside the event list
	localparam logic [EVENT_W-1:0] EV_UNUSED_LOW = 4'd11;
	localparam logic [EVENT_W-1:0] EV_UNUSED_TOP = 4'd15;

	// Tracks the supervisor's mode and the reports it owes
	class mode_report_board;
		mmfsm_upd_t        pending[$];
		logic [MODE_W-1:0] mode_cur;
		logic [MODE_W-1:0] mode_prior;
		int unsigned       fail_count;
		int unsigned       reports_seen;

		function new();
			mode_cur     = MODE_UNINIT;
			mode_prior   = MODE_UNINIT;
			fail_count   = 0;
			reports_seen = 0;
		endfunction

		// Transition table; pairs not listed keep the mode
		function logic [MODE_W-1:0] next_mode(logic [MODE_W-1:0] m, logic [EVENT_W-1:0] ev);
			case (m)
				MODE_UNINIT: begin
					if (ev == EV_INIT) return MODE_IDLE;
				end
				MODE_IDLE: begin
					if (ev == EV_ENABLE) return MODE_READY;
				end
				MODE_READY: begin
					if (ev == EV_DISABLE) return MODE_IDLE;
					if (ev == EV_START) return MODE_ACCEL;
					if (ev == EV_HOME) return MODE_HOMING;
					if (ev == EV_FAULT) return MODE_ERROR;
				end
				MODE_ACCEL: begin
					if (ev == EV_DONE) return MODE_RUNNING;
					if (ev == EV_STOP) return MODE_DECEL;
					if (ev == EV_ESTOP) return MODE_STOPPING;
					if (ev == EV_FAULT) return MODE_ERROR;
				end
				MODE_RUNNING: begin
					if (ev == EV_DONE || ev == EV_STOP) return MODE_DECEL;
					if (ev == EV_ESTOP) return MODE_STOPPING;
					if (ev == EV_FAULT) return MODE_ERROR;
				end
				MODE_DECEL: begin
					if (ev == EV_DONE) return MODE_READY;
					if (ev == EV_ESTOP) return MODE_STOPPING;
					if (ev == EV_FAULT) return MODE_ERROR;
				end
				MODE_STOPPING: begin
					if (ev == EV_DONE) return MODE_READY;
					if (ev == EV_FAULT) return MODE_ERROR;
				end
				MODE_HOMING: begin
					if (ev == EV_HOME_DONE) return MODE_READY;
					if (ev == EV_ESTOP) return MODE_STOPPING;
					if (ev == EV_FAULT) return MODE_ERROR;
				end
				MODE_ERROR: begin
					if (ev == EV_CLEARED) return MODE_IDLE;
				end
				default: begin
				end
			endcase
			return m;
		endfunction

		// Advance the mode for one accepted transaction and queue its report
		function void note_request(logic cmd, logic [EVENT_W-1:0] ev);
			mmfsm_upd_t        want;
			logic [MODE_W-1:0] nxt;
			nxt = (cmd == CMD_RESET) ? MODE_IDLE : next_mode(mode_cur, ev);
			want.changed = (cmd == CMD_RESET) || (nxt != mode_cur);
			if (want.changed) begin
				mode_prior = mode_cur;
				mode_cur   = nxt;
			end
			want.mode      = mode_cur;
			want.prior     = mode_prior;
			want.may_move  = (mode_cur == MODE_READY);
			want.in_motion = (mode_cur == MODE_ACCEL) || (mode_cur == MODE_RUNNING) ||
				(mode_cur == MODE_DECEL);
			pending.push_back(want);
		endfunction

		function void compare_field(string name, logic [MODE_W-1:0] want, logic [MODE_W-1:0] got);
			if (got !== want) begin
				$error("report %0d %s: expected %0d, got %0d", reports_seen, name, want, got);
				fail_count++;
			end
		endfunction

		// Match one accepted report against the oldest expected one
		function void check_report(mmfsm_upd_t got);
			mmfsm_upd_t want;
			reports_seen++;
			if (pending.size() == 0) begin
				$error("report %0d arrived with none expected", reports_seen);
				fail_count++;
				return;
			end
			want = pending.pop_front();
			compare_field("changed", MODE_W'(want.changed), MODE_W'(got.changed));
			compare_field("mode_now", want.mode, got.mode);
			compare_field("mode_before", want.prior, got.prior);
			compare_field("may_move", MODE_W'(want.may_move), MODE_W'(got.may_move));
			compare_field("in_motion", MODE_W'(want.in_motion), MODE_W'(got.in_motion));
		endfunction
	endclass

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic                 command    = CMD_EVENT;
	logic [EVENT_W-1:0]   event_code = EV_INIT;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic                 changed;
	logic [MODE_W-1:0]    mode_now;
	logic [MODE_W-1:0]    mode_before;
	logic                 may_move;
	logic                 in_motion;

	bit                   quiet_tail = 1'b0;
	int unsigned          quiet_cycles = 0;
	mode_report_board     board = new();

	motor_motion_mode_fsm_top u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one transaction, hold it until accepted, then maybe pause
	task automatic send_item(input logic cmd, input logic [EVENT_W-1:0] ev, input bit may_pause);
		@(negedge clk);
		in_valid   <= 1'b1;
		command    <= cmd;
		event_code <= ev;
		do @(posedge clk); while (in_stall);
		board.note_request(cmd, ev);
		if (may_pause && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	endtask

	// Pick an event that moves the current mode, if one exists
	function automatic logic [EVENT_W-1:0] pick_move(logic [MODE_W-1:0] m);
		logic [EVENT_W-1:0] ev;
		ev = EV_INIT;
		for (int k = 0; k < 32; k++) begin
			ev = EVENT_W'($urandom_range(0, EV_HOME_DONE));
			if (board.next_mode(m, ev) != m) return ev;
		end
		return ev;
	endfunction

	// Stimulus: directed walk through the table, then random traffic
	initial begin : stimulus
		int                 roll;
		logic               cmd;
		logic [EVENT_W-1:0] ev;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// uninitialized ignores everything but init, undefined codes included
		send_item(CMD_EVENT, EV_ESTOP, 1'b0);
		send_item(CMD_EVENT, EV_UNUSED_TOP, 1'b0);
		send_item(CMD_EVENT, EV_INIT, 1'b0);
		// forced reset while already idle still counts as a transition
		send_item(CMD_RESET, EV_UNUSED_TOP, 1'b0);
		send_item(CMD_EVENT, EV_ENABLE, 1'b0);
		send_item(CMD_EVENT, EV_HOME, 1'b0);
		send_item(CMD_EVENT, EV_START, 1'b0);
		send_item(CMD_EVENT, EV_HOME_DONE, 1'b0);
		send_item(CMD_EVENT, EV_START, 1'b0);
		send_item(CMD_EVENT, EV_DONE, 1'b0);
		send_item(CMD_EVENT, EV_UNUSED_LOW, 1'b0);
		send_item(CMD_EVENT, EV_STOP, 1'b0);
		send_item(CMD_EVENT, EV_ESTOP, 1'b0);
		send_item(CMD_EVENT, EV_DONE, 1'b0);
		send_item(CMD_EVENT, EV_FAULT, 1'b0);
		send_item(CMD_EVENT, EV_INIT, 1'b0);
		send_item(CMD_EVENT, EV_CLEARED, 1'b0);
		send_item(CMD_EVENT, EV_ENABLE, 1'b0);
		send_item(CMD_EVENT, EV_DISABLE, 1'b0);
		send_item(CMD_EVENT, EV_ENABLE, 1'b0);
		send_item(CMD_EVENT, EV_START, 1'b0);
		send_item(CMD_RESET, EV_INIT, 1'b0);

		// mostly legal moves, some stray events and forced resets
		for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				cmd = CMD_RESET;
				ev  = EVENT_W'($urandom_range(0, 15));
			end else if (roll < 25) begin
				cmd = CMD_EVENT;
				ev  = EVENT_W'($urandom_range(0, 15));
			end else begin
				cmd = CMD_EVENT;
				ev  = pick_move(board.mode_cur);
			end
			send_item(cmd, ev, !quiet_tail && ((n / 150) % 2 == 1));
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain outstanding reports, then allow for stray ones
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fail_count == 0) begin
			$display("motor_motion_mode_fsm_top: match");
		end else begin
			$display("motor_motion_mode_fsm_top: mismatch");
		end
		$finish;
	end

	// Result side: random stall bursts, calm windows and two long hold-offs
	initial begin : result_sink
		int          burst;
		int unsigned window;
		int unsigned squeeze_at;
		burst      = 0;
		window     = 0;
		squeeze_at = 300;
		forever begin
			@(negedge clk);
			window++;
			if (!quiet_tail && squeeze_at <= 700 && board.reports_seen >= squeeze_at) begin
				// hold off long enough to back up the input side
				out_stall <= 1'b1;
				repeat (SQUEEZE_LEN) @(negedge clk);
				squeeze_at += 400;
			end else if (!quiet_tail && burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else if (!quiet_tail && (window % 400) < 200 && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				burst = $urandom_range(1, 7) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Check each accepted report
	always @(posedge clk) begin : report_monitor
		mmfsm_upd_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.changed   = changed;
			got.mode      = mode_now;
			got.prior     = mode_before;
			got.may_move  = may_move;
			got.in_motion = in_motion;
			board.check_report(got);
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("motor_motion_mode_fsm_top: mismatch");
				$finish;
			end
		end
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/mmfsm_pkg.sv
hw/rtl/mmfsm_next.sv
hw/rtl/motor_motion_mode_fsm_top.sv
tb/sv/testbench.sv
